[src/dar_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dar_pkg: shared definitions for the deadband archive ring
// Field widths, register indexes, deadband mode codes and the item types
// passed between the front, the queue and the back.
// ----------------------------------------------------------------------------
package dar_pkg;

	localparam int RING_DEPTH_DEF = 1024;

	localparam int VAL_W      = 48;
	localparam int SEC_W      = 32;
	localparam int NSEC_W     = 30;
	localparam int SEV_W      = 2;
	localparam int MODE_W     = 3;
	localparam int PCT_W      = 15;
	localparam int MASK_W     = 16;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam int IN_BITS = VAL_W + SEV_W + 1 + SEC_W + NSEC_W + 1;
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

	localparam int DIFF_W = VAL_W;
	localparam int PROD_W = VAL_W + PCT_W;

	localparam int FIFO_DEPTH = 4;
	localparam int ENTRY_W    = VAL_W + SEC_W + NSEC_W + SEV_W;

	// relative band test: diff * 100 * 256 > |last| * pct(Q7.8)
	localparam logic [PCT_W-1:0] BAND_SCALE = 15'd25600;

	localparam logic [SEV_W-1:0] SEV_INVALID = 2'd3;

	localparam logic [MODE_W-1:0] MODE_ABS     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REL     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ABS_AND = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ABS_OR  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ANY     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ALWAYS  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_NEVER   = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ABS_BAND  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REL_PCT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MASK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_QUIET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_INT  = 3'd5;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [VAL_W-1:0]  abs_band;
		logic [PCT_W-1:0]  rel_pct;
		logic [MASK_W-1:0] bit_mask;
		logic [SEC_W-1:0]  max_quiet;
		logic [SEC_W-1:0]  snap_interval;
	} dar_cfg_t;

	// decided item, front to back
	typedef struct packed {
		logic              archived;
		logic [VAL_W-1:0]  value;
		logic [SEC_W-1:0]  seconds;
		logic [NSEC_W-1:0] nanoseconds;
		logic [SEV_W-1:0]  severity;
		logic              flush;
	} dar_item_t;

endpackage

[src/dar_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dar_ram: generic single write port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/dar_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dar_front: sample intake and archive decision
// Stage 1 forms the effective value and the band products for both possible
// last archived values; stage 2 picks one and decides whether to archive.
// ----------------------------------------------------------------------------
module dar_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dar_pkg::dar_cfg_t         cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [dar_pkg::IN_W-1:0]  in_data,
	output logic                      push,
	input  logic                      queue_full,
	output dar_pkg::dar_item_t        push_item
);
	import dar_pkg::*;

	localparam int SEV_LO   = VAL_W;
	localparam int ALARM_LO = SEV_LO + SEV_W;
	localparam int SEC_LO   = ALARM_LO + 1;
	localparam int NSEC_LO  = SEC_LO + SEC_W;
	localparam int FLUSH_LO = NSEC_LO + NSEC_W;

	function automatic logic [DIFF_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [VAL_W:0] d;
		d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		return d[VAL_W] ? DIFF_W'(-d) : d[DIFF_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
		return v[VAL_W-1] ? -v : v;
	endfunction

	// input fields
	logic [VAL_W-1:0]  smp;
	logic [SEV_W-1:0]  sev;
	logic              alarm;
	logic [SEC_W-1:0]  secs;
	logic [NSEC_W-1:0] nsec;
	logic              flush;

	assign smp   = in_data[0 +: VAL_W];
	assign sev   = in_data[SEV_LO +: SEV_W];
	assign alarm = in_data[ALARM_LO];
	assign secs  = in_data[SEC_LO +: SEC_W];
	assign nsec  = in_data[NSEC_LO +: NSEC_W];
	assign flush = in_data[FLUSH_LO];

	logic              mask_mode;
	logic              invalid;
	logic [VAL_W-1:0]  smp_neg;
	logic [MASK_W-1:0] int_lo;
	logic [VAL_W-1:0]  masked_val;
	logic [VAL_W-1:0]  val_in;
	logic              adv;
	logic [VAL_W-1:0]  cur_q;

	// integer part truncated toward zero, then low 16 bits
	assign mask_mode  = |cfg.bit_mask;
	assign invalid    = (sev == SEV_INVALID);
	assign smp_neg    = -smp;
	assign int_lo     = smp[VAL_W-1] ? -(smp_neg[FRAC_W +: MASK_W])
	                                 : smp[FRAC_W +: MASK_W];
	assign masked_val = VAL_W'({int_lo & cfg.bit_mask, FRAC_W'(0)});
	assign val_in     = invalid ? cur_q : (mask_mode ? masked_val : smp);

	// stage 1
	logic              v_s1;
	logic [VAL_W-1:0]  val_s1;
	logic              band_s1;
	logic              alarm_s1;
	logic [SEC_W-1:0]  secs_s1;
	logic [NSEC_W-1:0] nsec_s1;
	logic [SEV_W-1:0]  sev_s1;
	logic              flush_s1;

	// stage 2
	logic              v_s2;
	logic              had_pred_s2;
	logic [VAL_W-1:0]  val_s2;
	logic              alarm_s2;
	logic [SEC_W-1:0]  secs_s2;
	logic [NSEC_W-1:0] nsec_s2;
	logic [SEV_W-1:0]  sev_s2;
	logic              flush_s2;
	logic [DIFF_W-1:0] diff_p_s2, diff_h_s2;
	logic [PROD_W-1:0] lhs_p_s2, lhs_h_s2;
	logic [PROD_W-1:0] rhs_p_s2, rhs_h_s2;

	// committed decision state
	logic              last_arch_q;
	logic [VAL_W-1:0]  lastv_q;
	logic [SEC_W-1:0]  lta_q;

	// stage 2 decision
	logic              sel_p;
	logic [DIFF_W-1:0] diff;
	logic [PROD_W-1:0] lhs, rhs;
	logic              abs_hit, rel_hit, quiet, band_arch, arch;

	// whole front moves together so a valid stage 2 item is always stage 1's predecessor
	assign adv      = !v_s2 || !queue_full;
	assign in_ready = adv;

	// band terms against both candidates: predecessor's value or held value
	logic [DIFF_W-1:0] diff_p, diff_h;
	logic [PROD_W-1:0] lhs_p, lhs_h, rhs_p, rhs_h;

	assign diff_p = band_s1 ? abs_diff(val_s1, val_s2) : '0;
	assign diff_h = band_s1 ? abs_diff(val_s1, lastv_q) : '0;
	assign lhs_p  = diff_p * BAND_SCALE;
	assign lhs_h  = diff_h * BAND_SCALE;
	assign rhs_p  = band_s1 ? magnitude(val_s2) * cfg.rel_pct : '0;
	assign rhs_h  = band_s1 ? magnitude(lastv_q) * cfg.rel_pct : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			cur_q       <= '0;
			v_s2        <= 1'b0;
			had_pred_s2 <= 1'b0;
			last_arch_q <= 1'b0;
			lastv_q     <= '0;
			lta_q       <= '0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			had_pred_s2 <= v_s2;
			if (in_valid) begin
				cur_q <= val_in;
			end
			if (v_s2) begin
				last_arch_q <= arch;
				if (arch) begin
					lastv_q <= val_s2;
					lta_q   <= secs_s2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (in_valid) begin
				val_s1   <= val_in;
				band_s1  <= !invalid && !mask_mode;
				alarm_s1 <= alarm;
				secs_s1  <= secs;
				nsec_s1  <= nsec;
				sev_s1   <= sev;
				flush_s1 <= flush;
			end
			val_s2    <= val_s1;
			alarm_s2  <= alarm_s1;
			secs_s2   <= secs_s1;
			nsec_s2   <= nsec_s1;
			sev_s2    <= sev_s1;
			flush_s2  <= flush_s1;
			diff_p_s2 <= diff_p;
			diff_h_s2 <= diff_h;
			lhs_p_s2  <= lhs_p;
			lhs_h_s2  <= lhs_h;
			rhs_p_s2  <= rhs_p;
			rhs_h_s2  <= rhs_h;
		end
	end

	assign sel_p   = had_pred_s2 && last_arch_q;
	assign diff    = sel_p ? diff_p_s2 : diff_h_s2;
	assign lhs     = sel_p ? lhs_p_s2 : lhs_h_s2;
	assign rhs     = sel_p ? rhs_p_s2 : rhs_h_s2;
	assign abs_hit = diff > cfg.abs_band;
	assign rel_hit = lhs > rhs;
	assign quiet   = (secs_s2 - lta_q) > cfg.max_quiet;

	always_comb begin
		case (cfg.mode)
			MODE_ABS:     band_arch = abs_hit;
			MODE_REL:     band_arch = rel_hit;
			MODE_ABS_AND: band_arch = abs_hit && rel_hit;
			MODE_ABS_OR:  band_arch = abs_hit || rel_hit;
			MODE_ANY:     band_arch = |diff;
			MODE_ALWAYS:  band_arch = 1'b1;
			MODE_NEVER:   band_arch = 1'b0;
			default:      band_arch = 1'b0;
		endcase
	end

	assign arch = alarm_s2 || quiet ||
	              (mask_mode ? (val_s2 != lastv_q) : band_arch);

	assign push                  = v_s2 && !queue_full;
	assign push_item.archived    = arch;
	assign push_item.value       = val_s2;
	assign push_item.seconds     = secs_s2;
	assign push_item.nanoseconds = nsec_s2;
	assign push_item.severity    = sev_s2;
	assign push_item.flush       = flush_s2;

endmodule

[src/dar_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dar_fifo: short queue between front and back
// Flop based, count tracked, push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
module dar_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

[src/dar_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dar_back: ring write, fill tracking and snapshot flag
// Takes decided items from the queue, writes archived ones to the ring and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module dar_back #(
	parameter int RING_DEPTH = dar_pkg::RING_DEPTH_DEF,
	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
	localparam int FW = $clog2(RING_DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dar_pkg::dar_cfg_t         cfg,
	input  logic                      item_valid,
	output logic                      item_pop,
	input  dar_pkg::dar_item_t        item,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic                      res_archived,
	output logic [IW-1:0]             res_index,
	output logic [FW-1:0]             res_fill,
	output logic                      res_snapshot,
	output logic [dar_pkg::VAL_W-1:0] res_value
);
	import dar_pkg::*;

	localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
	localparam logic [IW-1:0] HALF_IDX = IW'(RING_DEPTH / 2);

	logic [IW-1:0]    idx_q;
	logic [FW-1:0]    used_q;
	logic [SEC_W-1:0] lst_q;
	logic             valid_q;

	logic [IW-1:0] next_idx;
	logic [FW-1:0] next_used;
	logic          snap_point;
	logic          snap;

	assign item_pop  = item_valid && (!valid_q || res_ready);
	assign next_idx  = !item.archived ? idx_q : ((idx_q == LAST_IDX) ? '0 : idx_q + 1'b1);
	assign next_used = (item.archived && used_q != FW'(RING_DEPTH)) ? used_q + 1'b1 : used_q;
	assign snap_point = (next_idx == '0) || (next_idx == HALF_IDX) ||
	                    ((item.seconds - lst_q) >= cfg.snap_interval);
	assign snap       = snap_point || item.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= LAST_IDX;
			used_q  <= '0;
			lst_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (item_pop) begin
				idx_q  <= next_idx;
				used_q <= next_used;
				if (snap_point) begin
					lst_q <= item.seconds;
				end
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			res_archived <= item.archived;
			res_index    <= next_idx;
			res_fill     <= next_used;
			res_snapshot <= snap;
			res_value    <= item.value;
		end
	end

	assign res_valid = valid_q;

	dar_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (item_pop && item.archived),
		.waddr(next_idx),
		.wdata({item.value, item.seconds, item.nanoseconds, item.severity}),
		.re   (1'b0),
		.raddr('0),
		.rdata()
	);

endmodule

[src/deadband_archive_ring_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_archive_ring_core: deadband filter feeding a sample ring
// Decides per sample whether to archive it, stores archived samples in a
// ring and reports index, fill level and when a snapshot is due.
// ----------------------------------------------------------------------------
// Usage:
//  - Samples arrive on the s_t* stream, one item per handshake; each item
//    gives exactly one result item on the m_t* stream, in order.
//  - Settings are written through cfg_we/cfg_index/cfg_wdata while no item is
//    in flight; a write to an index past the last register is dropped.
//  - Throughput: one item per clock while the queue has room. The front is a two stage pipeline whose
//    archive decision feeds back every cycle; band products are formed for
//    both possible last archived values so the feedback stays one compare.
//  - Path: an accepted item passes stage 1, stage 2, the queue and the
//    output register before its result is valid.
//  - When m_tready is low, the output register holds its result, the
//    four entry queue fills, and only then s_tready drops.
//  - Reset: all settings 0, ring index at depth minus one, fill count 0,
//    last archived value and times 0. Ring contents stay undefined; the ring
//    is written only, readout lives elsewhere.
// ----------------------------------------------------------------------------
module deadband_archive_ring_core #(
	parameter int RING_DEPTH = dar_pkg::RING_DEPTH_DEF,
	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
	localparam int FW = $clog2(RING_DEPTH + 1),
	localparam int OUT_BITS = 1 + IW + FW + 1 + dar_pkg::VAL_W,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [dar_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dar_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// sample stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// sample, severity, alarm_changed, seconds, nanoseconds, flush, zero pad
	input  logic [dar_pkg::IN_W-1:0]       s_tdata,
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// archived, write_index, fill_count, snapshot_due, effective_value, pad
	output logic [OUT_W-1:0]               m_tdata
);
	import dar_pkg::*;

	dar_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:      cfg_q.mode          <= cfg_wdata[MODE_W-1:0];
				REG_ABS_BAND:  cfg_q.abs_band      <= cfg_wdata[VAL_W-1:0];
				REG_REL_PCT:   cfg_q.rel_pct       <= cfg_wdata[PCT_W-1:0];
				REG_BIT_MASK:  cfg_q.bit_mask      <= cfg_wdata[MASK_W-1:0];
				REG_MAX_QUIET: cfg_q.max_quiet     <= cfg_wdata[SEC_W-1:0];
				REG_SNAP_INT:  cfg_q.snap_interval <= cfg_wdata[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	// front -> queue
	logic      push;
	logic      queue_full;
	dar_item_t push_item;

	dar_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.push      (push),
		.queue_full(queue_full),
		.push_item (push_item)
	);

	// queue -> back
	logic                  queue_empty;
	logic                  pop;
	logic [$bits(dar_item_t)-1:0] pop_data;
	dar_item_t             pop_item;

	assign pop_item = pop_data;

	dar_fifo #(
		.WIDTH($bits(dar_item_t)),
		.DEPTH(FIFO_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_item),
		.full  (queue_full),
		.pop   (pop),
		.rdata (pop_data),
		.empty (queue_empty)
	);

	logic             res_archived;
	logic [IW-1:0]    res_index;
	logic [FW-1:0]    res_fill;
	logic             res_snapshot;
	logic [VAL_W-1:0] res_value;

	dar_back #(
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (!queue_empty),
		.item_pop    (pop),
		.item        (pop_item),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res_archived(res_archived),
		.res_index   (res_index),
		.res_fill    (res_fill),
		.res_snapshot(res_snapshot),
		.res_value   (res_value)
	);

	assign m_tdata = OUT_W'({res_value, res_snapshot, res_fill, res_index, res_archived});

endmodule

[sim/deadband_archive_ring_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_archive_ring_checker: result predictor and scoreboard
// Watches the settings port and both streams, works out the result of every
// accepted sample from its own copy of the filter state and compares each
// result item field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module deadband_archive_ring_checker #(
	parameter int RING_DEPTH = dar_pkg::RING_DEPTH_DEF,
	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
	localparam int FW = $clog2(RING_DEPTH + 1),
	localparam int OUT_BITS = 1 + IW + FW + 1 + dar_pkg::VAL_W,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dar_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dar_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [dar_pkg::IN_W-1:0]       s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [OUT_W-1:0]               m_tdata,
	output int                             errors,
	output int                             pending
);
	import dar_pkg::*;

	// input item bit positions
	localparam int SEV_AT   = VAL_W;
	localparam int ALARM_AT = SEV_AT + SEV_W;
	localparam int SEC_AT   = ALARM_AT + 1;
	localparam int FLUSH_AT = SEC_AT + SEC_W + NSEC_W;

	typedef struct packed {
		logic              archived;
		logic [IW-1:0]     write_index;
		logic [FW-1:0]     fill_count;
		logic              snapshot_due;
		logic [VAL_W-1:0]  value;
	} ring_report_t;

	ring_report_t reports_due[$];
	ring_report_t want, seen;

	// settings
	logic [MODE_W-1:0] mode_r;
	logic [VAL_W-1:0]  abs_band_r;
	logic [PCT_W-1:0]  pct_r;
	logic [MASK_W-1:0] mask_r;
	logic [SEC_W-1:0]  quiet_r;
	logic [SEC_W-1:0]  snap_every_r;

	// filter and ring state
	logic [VAL_W-1:0]  last_kept;
	logic [VAL_W-1:0]  held_value;
	logic [SEC_W-1:0]  last_kept_sec;
	logic [SEC_W-1:0]  last_snap_sec;
	int unsigned       newest;
	int unsigned       used;

	task automatic compare_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endtask

	// decide one sample, advance the state, queue the result it must give
	task automatic judge_sample(input logic [IN_W-1:0] d);
		logic [63:0]       smp, lastv, val, diff, mag, lhs, rhs, trunc;
		logic [SEV_W-1:0]  sev;
		logic [SEC_W-1:0]  secs;
		logic              keep, abs_hit, rel_hit, snap;
		ring_report_t      r;
		smp   = {{16{d[VAL_W-1]}}, d[VAL_W-1:0]};
		sev   = d[SEV_AT +: SEV_W];
		secs  = d[SEC_AT +: SEC_W];
		lastv = {{16{last_kept[VAL_W-1]}}, last_kept};
		diff  = '0;
		lhs   = '0;
		rhs   = '0;

		if (sev == SEV_INVALID) begin
			val = {{16{held_value[VAL_W-1]}}, held_value};
		end else if (mask_r != '0) begin
			// integer part truncated toward zero, then mod 2^16
			trunc = smp[63] ? (64'd0 - ((64'd0 - smp) >> FRAC_W)) : (smp >> FRAC_W);
			val = {32'd0, trunc[MASK_W-1:0] & mask_r, 16'd0};
		end else begin
			val  = smp;
			diff = ($signed(val) > $signed(lastv)) ? val - lastv : lastv - val;
			mag  = lastv[63] ? 64'd0 - lastv : lastv;
			lhs  = diff * {49'd0, BAND_SCALE};
			rhs  = mag * {49'd0, pct_r};
		end

		keep = d[ALARM_AT];
		if (!keep) begin
			if (SEC_W'(secs - last_kept_sec) > quiet_r) begin
				keep = 1'b1;
			end else if (mask_r != '0) begin
				keep = val[VAL_W-1:0] != last_kept;
			end else begin
				abs_hit = diff > {16'd0, abs_band_r};
				rel_hit = lhs > rhs;
				case (mode_r)
					MODE_ABS:     keep = abs_hit;
					MODE_REL:     keep = rel_hit;
					MODE_ABS_AND: keep = abs_hit && rel_hit;
					MODE_ABS_OR:  keep = abs_hit || rel_hit;
					MODE_ANY:     keep = diff != '0;
					MODE_ALWAYS:  keep = 1'b1;
					default:      keep = 1'b0;
				endcase
			end
		end

		held_value = val[VAL_W-1:0];
		if (keep) begin
			last_kept     = val[VAL_W-1:0];
			last_kept_sec = secs;
			newest        = (newest + 1 >= RING_DEPTH) ? 0 : newest + 1;
			if (used < RING_DEPTH)
				used++;
		end

		snap = 1'b0;
		if (newest == 0 || newest == RING_DEPTH / 2 ||
				SEC_W'(secs - last_snap_sec) >= snap_every_r) begin
			snap          = 1'b1;
			last_snap_sec = secs;
		end
		if (d[FLUSH_AT])
			snap = 1'b1;

		r.archived     = keep;
		r.write_index  = newest[IW-1:0];
		r.fill_count   = used[FW-1:0];
		r.snapshot_due = snap;
		r.value        = val[VAL_W-1:0];
		reports_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r        = '0;
			abs_band_r    = '0;
			pct_r         = '0;
			mask_r        = '0;
			quiet_r       = '0;
			snap_every_r  = '0;
			last_kept     = '0;
			held_value    = '0;
			last_kept_sec = '0;
			last_snap_sec = '0;
			newest        = RING_DEPTH - 1;
			used          = 0;
			reports_due.delete();
			errors        = 0;
			pending       = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.archived     = m_tdata[0];
				seen.write_index  = m_tdata[IW:1];
				seen.fill_count   = m_tdata[IW+FW:IW+1];
				seen.snapshot_due = m_tdata[IW+FW+1];
				seen.value        = m_tdata[IW+FW+2 +: VAL_W];
				if (reports_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got %0h", $time, seen);
				end else begin
					want = reports_due.pop_front();
					compare_field("archived", 64'(want.archived), 64'(seen.archived));
					compare_field("write_index", 64'(want.write_index),
						64'(seen.write_index));
					compare_field("fill_count", 64'(want.fill_count),
						64'(seen.fill_count));
					compare_field("snapshot_due", 64'(want.snapshot_due),
						64'(seen.snapshot_due));
					compare_field("effective_value", 64'(want.value), 64'(seen.value));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:      mode_r       = cfg_wdata[MODE_W-1:0];
					REG_ABS_BAND:  abs_band_r   = cfg_wdata[VAL_W-1:0];
					REG_REL_PCT:   pct_r        = cfg_wdata[PCT_W-1:0];
					REG_BIT_MASK:  mask_r       = cfg_wdata[MASK_W-1:0];
					REG_MAX_QUIET: quiet_r      = cfg_wdata[SEC_W-1:0];
					REG_SNAP_INT:  snap_every_r = cfg_wdata[SEC_W-1:0];
					default:       ;
				endcase
			end
			if (s_tvalid && s_tready)
				judge_sample(s_tdata);
			pending = reports_due.size();
		end
	end

endmodule

[sim/deadband_archive_ring_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_archive_ring_core_test: stream-level test of the archive ring core
// Drives settings and timestamped samples with random gaps on both streams,
// a directed pass over the corner cases and then randomized setting phases.
// The checker beside the core predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module deadband_archive_ring_core_test;
	import dar_pkg::*;

	localparam int RING_DEPTH = RING_DEPTH_DEF;
	localparam int IW = $clog2(RING_DEPTH);
	localparam int FW = $clog2(RING_DEPTH + 1);
	localparam int OUT_W = ((1 + IW + FW + 1 + VAL_W + 7) / 8) * 8;

	localparam int RANDOM_ITEMS = 550;
	localparam int STALL_LIMIT  = 2000;   // cycles without any handshake
	localparam int LONG_HOLD    = 80;     // receiver back-pressure stretch

	localparam logic [SEV_W-1:0]     SEV_NONE   = 2'd0;
	localparam logic [SEV_W-1:0]     SEV_MINOR  = 2'd1;
	localparam logic [SEV_W-1:0]     SEV_MAJOR  = 2'd2;
	localparam logic [MODE_W-1:0]    MODE_SPARE = 3'd7;   // unused code, band test never stores
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;   // past the last register

	// Q32.16 constants
	localparam logic [VAL_W-1:0]  VAL_MAX  = 48'h7FFF_FFFF_FFFF;
	localparam logic [VAL_W-1:0]  VAL_MIN  = 48'h8000_0000_0000;
	localparam logic [VAL_W-1:0]  ONE      = 48'h0000_0001_0000;
	localparam logic [NSEC_W-1:0] NSEC_MAX = 30'd999_999_999;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	// sample, severity, alarm_changed, seconds, nanoseconds, flush, zero pad
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	// archived, write_index, fill_count, snapshot_due, effective_value, pad
	logic [OUT_W-1:0]  m_tdata;

	int errors;
	int pending;       // results still owed, from the checker
	int quiet_cycles;

	// per-phase idling control
	bit tx_calm;       // sender offers back to back
	bit rx_calm;       // receiver always ready
	int rx_hold_req;   // one-shot long receiver hold, in cycles

	deadband_archive_ring_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	deadband_archive_ring_checker #(.RING_DEPTH(RING_DEPTH)) scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: any handshake restarts the count
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("deadband_archive_ring_core_test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side. A gap is drawn after every accepted result; a pending
	// long-hold request replaces the draw once, so the queue fills behind it.
	initial begin : result_sink
		int gap;
		bit held;
		m_tready = 1'b0;
		held     = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req > 0 && !held) begin
				gap  = rx_hold_req;
				held = 1'b1;
			end else if (rx_calm) begin
				gap = 0;
			end else begin
				gap = $urandom_range(15, 0);
			end
			if (gap > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Offer one sample after a random gap and hold it until taken.
	task automatic offer_sample(input logic [VAL_W-1:0] value, input logic [SEV_W-1:0] sev,
			input logic alarm, input logic [SEC_W-1:0] secs,
			input logic [NSEC_W-1:0] nsec, input logic flush);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(15, 0);
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tdata  <= {{(IN_W - IN_BITS){1'b0}}, flush, nsec, secs, alarm, sev, value};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	// Stop offering, wait until every owed result is out, then idle briefly
	// for pipeline slack.
	task automatic settle;
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Unused upper data bits carry junk; the core must drop them.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		logic [63:0] junk;
		int width;
		junk = {$urandom, $urandom};
		case (idx)
			REG_MODE:     width = MODE_W;
			REG_ABS_BAND: width = VAL_W;
			REG_REL_PCT:  width = PCT_W;
			REG_BIT_MASK: width = MASK_W;
			default:      width = SEC_W;
		endcase
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value | (junk[CFG_DATA_W-1:0] << width);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [MODE_W-1:0] mode, input logic [VAL_W-1:0] band,
			input logic [PCT_W-1:0] pct, input logic [MASK_W-1:0] mask,
			input logic [SEC_W-1:0] quiet, input logic [SEC_W-1:0] snap_every);
		settle();
		write_reg(REG_MODE, CFG_DATA_W'(mode));
		write_reg(REG_ABS_BAND, band);
		write_reg(REG_REL_PCT, CFG_DATA_W'(pct));
		write_reg(REG_BIT_MASK, CFG_DATA_W'(mask));
		write_reg(REG_MAX_QUIET, CFG_DATA_W'(quiet));
		write_reg(REG_SNAP_INT, CFG_DATA_W'(snap_every));
	endtask

	initial begin : stimulus
		logic [63:0]       raw;
		logic [VAL_W-1:0]  smp, level, stride, band;
		logic [SEC_W-1:0]  clock_sec, quiet, snap_every;
		logic [PCT_W-1:0]  pct;
		logic [MASK_W-1:0] mask;
		logic [SEV_W-1:0]  sev;
		int                roll, shift, span, sent;
		bit                first;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		tx_calm     = 1'b0;
		rx_calm     = 1'b0;
		rx_hold_req = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// ---- directed part ----
		// absolute band of one unit, long quiet time, snapshot every 50 s
		configure(MODE_ABS, ONE, '0, '0, 32'd1000, 32'd50);
		write_reg(REG_SPARE, 48'hA5A5_5A5A_A5A5);   // must be dropped
		offer_sample('0, SEV_NONE, 1'b0, 32'd10, '0, 1'b0);               // no change
		offer_sample(VAL_MAX, SEV_MINOR, 1'b0, 32'd10, NSEC_MAX, 1'b0);  // first store: index 0
		offer_sample(VAL_MIN, SEV_MAJOR, 1'b0, 32'd11, 30'd1, 1'b0);     // full-scale swing
		offer_sample(VAL_MIN + 48'h8000, SEV_NONE, 1'b0, 32'd11, 30'd2, 1'b0); // inside band
		offer_sample(48'h1234_5678_9ABC, SEV_INVALID, 1'b0, 32'd12, 30'd3, 1'b0); // held value
		offer_sample(VAL_MIN + 48'h8000, SEV_NONE, 1'b1, 32'd12, 30'd4, 1'b0); // alarm forces store
		offer_sample(VAL_MIN + 48'h8000, SEV_NONE, 1'b0, 32'd13, 30'd5, 1'b1); // flush
		offer_sample(VAL_MIN, SEV_NONE, 1'b0, 32'hFFFF_FFFF, '0, 1'b0);  // quiet timeout
		// seconds wrap to 0 is one second later; inside band, so held differs from stored
		offer_sample(VAL_MIN + 48'h4000, SEV_NONE, 1'b0, 32'd0, NSEC_MAX, 1'b0);

		// masked mode, full mask
		configure(MODE_ABS, ONE, '0, 16'hFFFF, 32'd1000, 32'd50);
		offer_sample(VAL_MAX, SEV_INVALID, 1'b0, 32'd1, 30'd6, 1'b0);    // held != stored: store
		offer_sample(48'hFFFF_FFFE_8000, SEV_NONE, 1'b0, 32'd2, 30'd7, 1'b0); // -1.5 -> -1
		offer_sample(48'h0001_1170_4000, SEV_NONE, 1'b0, 32'd3, 30'd8, 1'b0); // 70000.25 wraps
		offer_sample(48'h0001_1170_0000, SEV_NONE, 1'b0, 32'd4, 30'd9, 1'b0); // same: no store

		configure(MODE_ABS, ONE, '0, 16'h00F0, 32'd1000, 32'd50);
		offer_sample(48'h0000_0ABC_DEF0, SEV_MINOR, 1'b0, 32'd5, 30'd10, 1'b0);

		// relative band of 10 %: a move of exactly 10 % stays, one LSB more stores
		configure(MODE_REL, '0, 15'd2560, '0, 32'd1000, 32'd50);
		offer_sample(48'h0000_0064_0000, SEV_NONE, 1'b1, 32'd6, 30'd11, 1'b0);
		offer_sample(48'h0000_006E_0000, SEV_NONE, 1'b0, 32'd7, 30'd12, 1'b0);
		offer_sample(48'h0000_006E_0001, SEV_NONE, 1'b0, 32'd8, 30'd13, 1'b0);

		configure(MODE_NEVER, '0, '0, '0, 32'd1000, 32'd50);
		offer_sample(VAL_MAX, SEV_NONE, 1'b0, 32'd9, 30'd14, 1'b0);
		configure(MODE_SPARE, '0, '0, '0, 32'd1000, 32'd50);
		offer_sample(VAL_MIN, SEV_NONE, 1'b0, 32'd10, 30'd15, 1'b0);
		configure(MODE_ANY, '0, '0, '0, 32'd1000, 32'd50);
		offer_sample(VAL_MIN, SEV_NONE, 1'b0, 32'd11, 30'd16, 1'b0);    // changed: store
		offer_sample(VAL_MIN, SEV_NONE, 1'b0, 32'd12, 30'd17, 1'b0);    // unchanged

		// ---- random phases ----
		// Samples random-walk around a level with steps of every magnitude, so
		// both band tests see near misses; a fraction are wild values.
		level     = '0;
		clock_sec = 32'd100;
		sent      = 0;
		first     = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			raw = {$urandom, $urandom};
			case ($urandom_range(3, 0))
				0:       band = '0;
				1:       band = VAL_MAX | VAL_MIN;
				default: band = raw[VAL_W-1:0] & ((48'd1 << $urandom_range(24, 0)) - 48'd1);
			endcase
			case ($urandom_range(2, 0))
				0:       pct = '0;
				1:       pct = BAND_SCALE;
				default: pct = PCT_W'($urandom_range(25600, 0));
			endcase
			roll = $urandom_range(99, 0);
			mask = (roll < 60) ? '0 : (roll < 70) ? 16'hFFFF
			                                      : MASK_W'($urandom_range(65535, 1));
			case ($urandom_range(3, 0))
				0:       quiet = '0;
				1:       quiet = 32'hFFFF_FFFF;
				2:       quiet = $urandom_range(20, 1);
				default: quiet = $urandom;
			endcase
			case ($urandom_range(2, 0))
				0:       snap_every = '0;
				1:       snap_every = 32'hFFFF_FFFF;
				default: snap_every = $urandom_range(30, 1);
			endcase
			configure(MODE_W'($urandom_range(7, 0)), band, pct, mask, quiet, snap_every);

			if (first) begin
				// receiver stalls long while the sender streams: the core fills up
				tx_calm     = 1'b1;
				rx_calm     = 1'b0;
				rx_hold_req = LONG_HOLD;
				span        = 40;
				first       = 1'b0;
			end else begin
				tx_calm = ($urandom_range(3, 0) == 0);
				rx_calm = ($urandom_range(3, 0) == 0);
				span    = $urandom_range(60, 15);
			end

			repeat (span) begin
				raw  = {$urandom, $urandom};
				roll = $urandom_range(99, 0);
				if (roll < 12) begin
					smp = raw[VAL_W-1:0];
				end else if (roll < 15) begin
					smp = (roll == 12) ? VAL_MAX : (roll == 13) ? VAL_MIN : '0;
				end else begin
					shift  = $urandom_range(40, 0);
					stride = raw[VAL_W-1:0] & ((48'd1 << shift) - 48'd1);
					smp    = raw[63] ? level - stride : level + stride;
				end
				if ($urandom_range(1, 0) == 1)
					level = smp;
				if ($urandom_range(19, 0) == 0)
					clock_sec = $urandom;
				else
					clock_sec = clock_sec + $urandom_range(3, 0);
				sev = ($urandom_range(9, 0) == 0) ? SEV_INVALID
				                                  : SEV_W'($urandom_range(2, 0));
				offer_sample(smp, sev, $urandom_range(9, 0) == 0, clock_sec,
					NSEC_W'($urandom_range(999_999_999, 0)), $urandom_range(9, 0) == 0);
				sent++;
			end
		end

		settle();
		if (errors == 0)
			$display("deadband_archive_ring_core_test passed");
		else
			$display("deadband_archive_ring_core_test failed");
		$finish;
	end

endmodule
